// ===== rtl/core/ccs_pkg.sv =====
// Shared types, constants and helpers for the colour code stripper.
package ccs_pkg;

   localparam logic [7:0] CARET_BYTE  = 8'h5E;
   localparam logic [7:0] END_BYTE    = 8'h00;
   localparam int         CODE_DIGITS = 6;
   localparam int         HELD_MAX    = CODE_DIGITS - 1;
   localparam int         PEND_W      = 3;
   localparam int         DIGIT_IDX_W = $clog2(HELD_MAX);
   localparam int         STEP_W      = 3;
   localparam int         LIMIT_W     = 12;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd511;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      TAIL_NONE,
      TAIL_BYTE,
      TAIL_END
   } tail_type;

   // one queued command: flush of held bytes, then an optional tail result
   typedef struct packed {
      logic [PEND_W-1:0]              flush_len;
      logic [HELD_MAX-1:0][7:0]       digits;
      tail_type                       tail;
      logic [7:0]                     char_val;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_head_type;

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) ||
             (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
   endfunction

endpackage

// ===== rtl/core/color_code_stripper_unit.sv =====
// Top level of the colour code stripper: front end, command queue, back end.
// A byte that yields a result passes the command queue, then the back end's output register.
// Throughput: one transaction per cycle for plain bytes and swallowed code digits,
// while the queue has room. A broken code flushes caret plus held digits at one result
// per cycle unless stalled (seven at most), paced by the back end's single output register.
// Reset (synchronous, active high) clears held state, counts, queue and rsp_valid; limit = 511.
module color_code_stripper_unit (
   input  logic        clock,
   input  logic        reset,
   // input byte stream
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_in,
   // result stream
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_char_out,
   output logic        rsp_has_byte,
   output logic        rsp_end_of_text,
   // output limit register
   input  logic        csr_write_en,
   input  logic [11:0] csr_write_data
);

   // output limit; the user must write it only while the block is idle, the block does not enforce it
   logic [ccs_pkg::LIMIT_W-1:0] limit_ff, limit_in;

   logic                 q_full;
   logic                 push;
   ccs_pkg::cmd_type     push_cmd;
   logic                 pop;
   ccs_pkg::q_head_type  head;

   assign limit_in = csr_write_en ? csr_write_data : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= ccs_pkg::LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   // front end: classifies each transaction, holds caret and digits of a
   // code in progress, and queues a command only when something is due
   ccs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_char_in (req_char_in),
      .q_full      (q_full),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   // two-entry queue: lets input flow on while a flush burst drains
   ccs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (pop),
      .head     (head)
   );

   // back end: emits flush bytes then the tail, counts bytes against limit
   ccs_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .limit           (limit_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_char_out    (rsp_char_out),
      .rsp_has_byte    (rsp_has_byte),
      .rsp_end_of_text (rsp_end_of_text)
   );

endmodule

// ===== rtl/core/ccs_front.sv =====
// Front end: accepts text bytes, tracks held colour codes, issues commands.
module ccs_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_char_in,
   input  logic             q_full,
   output logic             push,
   output ccs_pkg::cmd_type push_cmd
);

   logic [ccs_pkg::PEND_W-1:0]             pend_ff, pend_in;
   logic [ccs_pkg::HELD_MAX-1:0][7:0]      digits_ff, digits_in;
   logic                                   accept;
   logic                                   absorb;
   logic [ccs_pkg::DIGIT_IDX_W-1:0]        wr_idx;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   // hex digit after a caret is swallowed (terminator is never hex)
   assign absorb = (pend_ff != '0) && ccs_pkg::is_hex(req_char_in);
   assign wr_idx = ccs_pkg::DIGIT_IDX_W'(pend_ff - ccs_pkg::PEND_W'(1));

   always_comb begin
      pend_in   = pend_ff;
      digits_in = digits_ff;
      push      = 1'b0;

      push_cmd.flush_len = pend_ff;
      push_cmd.digits    = digits_ff;
      push_cmd.char_val  = req_char_in;
      if (req_char_in == ccs_pkg::END_BYTE) begin
         push_cmd.tail = ccs_pkg::TAIL_END;
      end else if (req_char_in == ccs_pkg::CARET_BYTE) begin
         push_cmd.tail = ccs_pkg::TAIL_NONE;
      end else begin
         push_cmd.tail = ccs_pkg::TAIL_BYTE;
      end

      if (accept) begin
         if (absorb) begin
            if (pend_ff >= ccs_pkg::PEND_W'(ccs_pkg::CODE_DIGITS)) begin
               pend_in = '0;   // full code dropped
            end else begin
               digits_in[wr_idx] = req_char_in;
               pend_in           = pend_ff + ccs_pkg::PEND_W'(1);
            end
         end else begin
            push    = (pend_ff != '0) || (push_cmd.tail != ccs_pkg::TAIL_NONE);
            pend_in = (req_char_in == ccs_pkg::CARET_BYTE) ? ccs_pkg::PEND_W'(1) : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
      digits_ff <= digits_in;
   end

endmodule

// ===== rtl/core/ccs_queue.sv =====
// Short command queue between front end and back end.
module ccs_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ccs_pkg::cmd_type    push_cmd,
   output logic                full,
   input  logic                pop,
   output ccs_pkg::q_head_type head
);

   ccs_pkg::cmd_type                 entries_ff [ccs_pkg::QUEUE_DEPTH];
   logic [ccs_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [ccs_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [ccs_pkg::QCNT_W-1:0]       count_ff, count_in;

   function automatic logic [ccs_pkg::QPTR_W-1:0] ptr_next(
      input logic [ccs_pkg::QPTR_W-1:0] p);
      return (p == ccs_pkg::QPTR_W'(ccs_pkg::QUEUE_DEPTH - 1)) ?
             '0 : p + ccs_pkg::QPTR_W'(1);
   endfunction

   assign full       = (count_ff == ccs_pkg::QCNT_W'(ccs_pkg::QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + ccs_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - ccs_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/core/ccs_back.sv =====
// Back end: walks each command one result per cycle while the output is free, applies the output limit.
module ccs_back (
   input  logic                         clock,
   input  logic                         reset,
   input  ccs_pkg::q_head_type          head,
   output logic                         pop,
   input  logic [ccs_pkg::LIMIT_W-1:0]  limit,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [7:0]                   rsp_char_out,
   output logic                         rsp_has_byte,
   output logic                         rsp_end_of_text
);

   logic [ccs_pkg::STEP_W-1:0]      step_ff, step_in;
   logic [ccs_pkg::LIMIT_W-1:0]     emitted_ff, emitted_in;
   logic                            valid_ff, valid_in;
   logic [7:0]                      char_ff, char_in;
   logic                            has_byte_ff, has_byte_in;
   logic                            eot_ff, eot_in;

   logic                            out_free;
   logic                            advance;
   logic                            in_flush;
   logic                            is_end;
   logic                            drop;
   logic                            last;
   logic [ccs_pkg::STEP_W-1:0]      total;
   logic [ccs_pkg::STEP_W-1:0]      step_plus;
   logic [ccs_pkg::DIGIT_IDX_W-1:0] dig_idx;
   logic [7:0]                      cur_byte;

   assign out_free  = !valid_ff || rsp_ready;
   assign advance   = head.valid && out_free;
   assign total     = ccs_pkg::STEP_W'(head.cmd.flush_len) +
                      ccs_pkg::STEP_W'(head.cmd.tail != ccs_pkg::TAIL_NONE);
   assign step_plus = step_ff + ccs_pkg::STEP_W'(1);
   assign last      = (step_plus == total);
   assign pop       = advance && last;

   assign in_flush = (step_ff < ccs_pkg::STEP_W'(head.cmd.flush_len));
   assign is_end   = !in_flush && (head.cmd.tail == ccs_pkg::TAIL_END);
   assign drop     = !is_end && (emitted_ff >= limit);
   assign dig_idx  = (step_ff == '0) ? '0 :
                     ccs_pkg::DIGIT_IDX_W'(step_ff - ccs_pkg::STEP_W'(1));

   always_comb begin
      if (!in_flush) begin
         cur_byte = head.cmd.char_val;
      end else if (step_ff == '0) begin
         cur_byte = ccs_pkg::CARET_BYTE;
      end else begin
         cur_byte = head.cmd.digits[dig_idx];
      end
   end

   always_comb begin
      step_in     = step_ff;
      emitted_in  = emitted_ff;
      valid_in    = valid_ff && !rsp_ready;
      char_in     = char_ff;
      has_byte_in = has_byte_ff;
      eot_in      = eot_ff;
      if (advance) begin
         step_in = last ? '0 : step_plus;
         if (is_end) begin
            valid_in    = 1'b1;
            char_in     = ccs_pkg::END_BYTE;
            has_byte_in = 1'b0;
            eot_in      = 1'b1;
            emitted_in  = '0;
         end else if (!drop) begin
            valid_in    = 1'b1;
            char_in     = cur_byte;
            has_byte_in = 1'b1;
            eot_in      = 1'b0;
            emitted_in  = emitted_ff + ccs_pkg::LIMIT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= '0;
         emitted_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         step_ff    <= step_in;
         emitted_ff <= emitted_in;
         valid_ff   <= valid_in;
      end
      char_ff     <= char_in;
      has_byte_ff <= has_byte_in;
      eot_ff      <= eot_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_char_out    = char_ff;
   assign rsp_has_byte    = has_byte_ff;
   assign rsp_end_of_text = eot_ff;

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      head.valid |-> (step_ff < total))
      else $error("step beyond command length");

   a_idle_step_zero: assert property (@(posedge clock) disable iff (reset)
      !head.valid |-> (step_ff == '0))
      else $error("step left mid-command with empty queue");

   a_end_clears_count: assert property (@(posedge clock) disable iff (reset)
      (advance && is_end) |=> (emitted_ff == '0) && valid_ff && eot_ff && !has_byte_ff)
      else $error("end marker did not reset emitted count");

endmodule

// ===== sim/tb_color_code_stripper_unit.sv =====
// Self-checking testbench for the colour code stripper: directed and random byte texts, checked result by result.
module tb_color_code_stripper_unit;

   // one expected result transaction
   typedef struct {
      logic [7:0] char_out;
      logic       has_byte;
      logic       end_of_text;
   } strip_result;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_in = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_char_out;
   logic        rsp_has_byte;
   logic        rsp_end_of_text;
   logic        csr_write_en = 1'b0;
   logic [11:0] csr_write_data = 12'd0;

   color_code_stripper_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_char_in    (req_char_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_char_out   (rsp_char_out),
      .rsp_has_byte   (rsp_has_byte),
      .rsp_end_of_text(rsp_end_of_text),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #2 clock = ~clock;

   // bytes still to be offered, and results still to arrive
   logic [7:0]  text_bytes_q[$];
   strip_result stripped_q[$];

   // shadow of the block's state
   logic [ccs_pkg::LIMIT_W-1:0] out_limit = ccs_pkg::LIMIT_RESET;
   logic [ccs_pkg::PEND_W-1:0]  held_cnt  = '0;
   logic [7:0]                  held_digits[ccs_pkg::HELD_MAX];
   logic [ccs_pkg::LIMIT_W-1:0] emit_cnt  = '0;

   int   fail_count = 0;
   int   items_queued = 0;
   logic idle_on  = 1'b1;    // random idling on both sides
   logic hold_arm = 1'b0;    // asks the receiver for one long hold-off
   logic req_fire = 1'b0;    // input transaction taken at the last rising edge

   function automatic logic hex_char(input logic [7:0] c);
      return (c inside {[8'h30:8'h39]}) || (c inside {[8'h41:8'h46]}) ||
             (c inside {[8'h61:8'h66]});
   endfunction

   // one output byte, unless the per-text limit has been reached
   function automatic void emit_char(input logic [7:0] b);
      strip_result r;
      if (emit_cnt >= out_limit) return;
      emit_cnt   = emit_cnt + 1'b1;
      r.char_out    = b;
      r.has_byte    = 1'b1;
      r.end_of_text = 1'b0;
      stripped_q.push_back(r);
   endfunction

   // expected results of one accepted input byte
   function automatic void strip_byte(input logic [7:0] c);
      strip_result r;
      int i;
      // digit of a code in progress: held, or the whole code dropped on the sixth
      if (held_cnt != 0 && c != ccs_pkg::END_BYTE && hex_char(c)) begin
         if (held_cnt >= ccs_pkg::CODE_DIGITS) begin
            held_cnt = '0;
         end else begin
            held_digits[held_cnt - 1] = c;
            held_cnt = held_cnt + 1'b1;
         end
         return;
      end
      // broken run: caret and held digits go out as they came
      if (held_cnt != 0) begin
         emit_char(ccs_pkg::CARET_BYTE);
         for (i = 0; i + 1 < held_cnt; i++)
            emit_char(held_digits[i]);
         held_cnt = '0;
      end
      if (c == ccs_pkg::END_BYTE) begin
         r.char_out    = 8'h00;
         r.has_byte    = 1'b0;
         r.end_of_text = 1'b1;
         stripped_q.push_back(r);
         emit_cnt = '0;
      end else if (c == ccs_pkg::CARET_BYTE) begin
         held_cnt = 3'd1;
      end else begin
         emit_char(c);
      end
   endfunction

   // -------------------------------------------------------------------------
   // Sender: offers queued bytes at the falling edge, with random gaps
   // -------------------------------------------------------------------------
   int send_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (send_gap > 0) begin
            send_gap  = send_gap - 1;
            req_valid <= 1'b0;
         end else if (text_bytes_q.size() > 0) begin
            req_valid   <= 1'b1;
            req_char_in <= text_bytes_q.pop_front();
            if (idle_on && $urandom_range(0, 7) == 0)
               send_gap = $urandom_range(1, 12);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: random stall bursts, plus one long hold-off on request so that
   // the internal queue fills and req_ready drops
   // -------------------------------------------------------------------------
   int   recv_gap  = 0;
   int   hold_left = 0;
   logic hold_done = 1'b0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_arm && !hold_done) begin
         hold_done = 1'b1;
         hold_left = 200;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap = recv_gap - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (idle_on && $urandom_range(0, 9) == 0)
            recv_gap = $urandom_range(1, 12);
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: predicts on each input transaction, checks each result transaction
   // against the oldest expectation
   // -------------------------------------------------------------------------
   strip_result want;
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && req_ready;
         // prediction first: the queue is FIFO, so older expectations stay in front
         if (req_valid && req_ready)
            strip_byte(req_char_in);
         if (rsp_valid && rsp_ready) begin
            if (stripped_q.size() == 0) begin
               $error("unexpected result: char_out %0h has_byte %0b end_of_text %0b",
                      rsp_char_out, rsp_has_byte, rsp_end_of_text);
               fail_count++;
            end else begin
               want = stripped_q.pop_front();
               if (rsp_char_out !== want.char_out) begin
                  $error("char_out: expected %0h, got %0h", want.char_out, rsp_char_out);
                  fail_count++;
               end
               if (rsp_has_byte !== want.has_byte) begin
                  $error("has_byte: expected %0b, got %0b", want.has_byte, rsp_has_byte);
                  fail_count++;
               end
               if (rsp_end_of_text !== want.end_of_text) begin
                  $error("end_of_text: expected %0b, got %0b",
                         want.end_of_text, rsp_end_of_text);
                  fail_count++;
               end
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   task automatic queue_byte(input logic [7:0] c);
      text_bytes_q.push_back(c);
      items_queued++;
   endtask

   task automatic queue_hex_digit();
      logic [7:0] pick;
      case ($urandom_range(0, 2))
         0:       pick = 8'(8'h30 + $urandom_range(0, 9));
         1:       pick = 8'(8'h41 + $urandom_range(0, 5));
         default: pick = 8'(8'h61 + $urandom_range(0, 5));
      endcase
      queue_byte(pick);
   endtask

   // random non-zero byte that is not a hex digit (the caret is allowed)
   function automatic logic [7:0] non_hex_byte();
      logic [7:0] b;
      b = 8'($urandom_range(1, 255));
      while (hex_char(b))
         b = 8'($urandom_range(1, 255));
      return b;
   endfunction

   // texts mostly made of codes, broken codes and plain bytes, with some raw noise
   task automatic queue_random_texts(input int target);
      int first, units, u, k, sel;
      first = items_queued;
      while (items_queued - first < target) begin
         units = $urandom_range(1, 10);
         for (u = 0; u < units; u++) begin
            sel = $urandom_range(0, 99);
            if (sel < 35) begin
               queue_byte(ccs_pkg::CARET_BYTE);
               repeat (ccs_pkg::CODE_DIGITS) queue_hex_digit();
            end else if (sel < 55) begin
               queue_byte(ccs_pkg::CARET_BYTE);
               k = $urandom_range(0, ccs_pkg::HELD_MAX);
               repeat (k) queue_hex_digit();
               if ($urandom_range(0, 5) == 0) queue_byte(ccs_pkg::END_BYTE);
               else queue_byte(non_hex_byte());
            end else if (sel < 62) begin
               queue_byte(8'($urandom_range(0, 255)));
            end else begin
               queue_byte(8'($urandom_range(1, 255)));
            end
         end
         if ($urandom_range(0, 9) != 0)
            queue_byte(ccs_pkg::END_BYTE);
      end
   endtask

   // wait until every byte is taken and every result has come, then let the
   // block settle (up to two queued flushes that are wholly dropped may still be
   // walking through the back end) before the limit register is touched
   task automatic drain();
      while (text_bytes_q.size() > 0 || req_valid || stripped_q.size() > 0)
         @(posedge clock);
      repeat (32) @(posedge clock);
   endtask

   task automatic write_limit(input logic [11:0] value);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      out_limit = value;
   endtask

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, at the reset limit: complete code in mixed case, high bytes
      queue_byte("a");  queue_byte(8'hFF);
      queue_byte(ccs_pkg::CARET_BYTE);
      queue_byte("1"); queue_byte("A"); queue_byte("2");
      queue_byte("b"); queue_byte("3"); queue_byte("C");
      // broken run, then a caret broken by a caret
      queue_byte(ccs_pkg::CARET_BYTE); queue_byte("1"); queue_byte("2"); queue_byte("g");
      queue_byte(ccs_pkg::CARET_BYTE); queue_byte(ccs_pkg::CARET_BYTE); queue_byte(8'h01);
      // terminator with five digits held, then an empty text
      queue_byte(8'h80); queue_byte(ccs_pkg::CARET_BYTE);
      queue_byte("f"); queue_byte("F"); queue_byte("9"); queue_byte("0"); queue_byte("e");
      queue_byte(ccs_pkg::END_BYTE);
      queue_byte(ccs_pkg::END_BYTE);
      drain();

      // limit lowered mid-text below the count already emitted
      write_limit(12'd4095);
      queue_byte("p"); queue_byte("q"); queue_byte("r"); queue_byte("s");
      queue_byte(ccs_pkg::CARET_BYTE); queue_byte("7");
      drain();
      write_limit(12'd3);
      queue_byte("t"); queue_byte(8'h7F); queue_byte(ccs_pkg::END_BYTE);
      queue_byte("u"); queue_byte("v"); queue_byte("w"); queue_byte("x");
      queue_byte(ccs_pkg::END_BYTE);
      drain();

      // nothing may pass: only end markers
      write_limit(12'd0);
      queue_random_texts(40);
      drain();

      write_limit(12'd4095);
      queue_random_texts(70);
      drain();

      // a small limit cuts most texts short
      write_limit(12'd5);
      queue_random_texts(60);
      drain();

      // long receiver hold-off while the sender keeps offering
      write_limit(12'd511);
      hold_arm = 1'b1;
      queue_random_texts(60);
      drain();

      // last part without idling
      write_limit(12'd200);
      idle_on = 1'b0;
      queue_random_texts(60);
      drain();
      repeat (16) @(posedge clock);

      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // watchdog, well beyond the slowest correct run
   initial begin
      #1000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
